// File: rtl/core/piecewise_linear_coeff_table_core_macros.svh
// assertion macros for the piecewise linear coefficient table core
`ifndef PIECEWISE_LINEAR_COEFF_TABLE_CORE_MACROS_SVH
`define PIECEWISE_LINEAR_COEFF_TABLE_CORE_MACROS_SVH
// implication checked every clock outside reset
`define PLC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("label failed");
// next-cycle implication checked every clock outside reset
`define PLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("label failed");
`endif

// File: rtl/core/plct_pkg.sv
// package with shared types and constants of the coefficient table core
`default_nettype none
package plct_pkg;
  localparam int MaxEntries = 64;
  localparam int IdxW = $clog2(MaxEntries);
  localparam int CntW = $clog2(MaxEntries + 1);
  localparam int TempW = 16;
  localparam int CoefW = 24;
  localparam int CfgW = 24;
  localparam int StW = 2;
  localparam int ProdW = 48;
  localparam int DivW = 49;
  localparam int DivCntW = 6;

  localparam logic [1:0] ReqWrite = 2'd0;
  localparam logic [1:0] ReqNorm = 2'd1;
  localparam logic [1:0] ReqQuery = 2'd2;

  localparam logic [1:0] CfgCount = 2'd0;
  localparam logic [1:0] CfgBase = 2'd1;
  localparam logic [1:0] CfgScale = 2'd2;

  localparam logic [StW-1:0] StOk = 2'd0;
  localparam logic [StW-1:0] StRange = 2'd1;
  localparam logic [StW-1:0] StZero = 2'd2;

  localparam logic [CoefW-1:0] CoefMax = {CoefW{1'b1}};

  typedef enum logic [3:0] {
    OpNone, OpWrite, OpRdAddr, OpScanCmp, OpSegRd, OpMul, OpDivStart, OpDivStep,
    OpInterp, OpNrdAddr, OpNmul, OpNwrite, OpFinish
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [IdxW-1:0]    addr;
    logic [StW-1:0]     st;
    logic               norm;
  } cmd_t;

  typedef struct packed {
    logic bracket;
    logic zero_w;
    logic div_done;
    logic base_zero;
  } stat_t;
endpackage
`default_nettype wire

// File: rtl/core/piecewise_linear_coeff_table_core.sv
// top level of the piecewise linear coefficient table core
// A request is taken when start is high and busy is low; one result follows
// with a one-cycle strobe that the receiver cannot stall. A write or an unused
// request code answers in the cycle right after it is taken and never raises
// busy. A query scans segments one by one (up to 63 segments), then runs
// the multiply, a 49-step serial divide and the final add; a query that
// brackets nothing answers once the scan ends. Normalize runs the
// interpolation at the base temperature, then a read, multiply, divide and
// write back for each entry, one entry at a time, set by the shared divider
// and the single ram port. Configuration writes are always ready.
`default_nettype none
module piecewise_linear_coeff_table_core import plct_pkg::*; (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  output logic             busy,
  input  wire [1:0]        req_type,
  input  wire [IdxW-1:0]   entry_index,
  input  wire [TempW-1:0]  temperature,
  input  wire [CoefW-1:0]  coefficient,
  output logic             result_valid,
  output logic [CoefW-1:0] coefficient_out,
  output logic [StW-1:0]   status,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  input  wire [1:0]        cfg_index,
  input  wire [CfgW-1:0]   cfg_data
);
  logic [CntW-1:0]  entry_count;
  logic [TempW-1:0] base_temperature;
  logic [CoefW-1:0] scaling_factor;
  logic             load_req, val_sel;
  cmd_t             cmd;
  stat_t            stat;
  logic [CoefW-1:0] value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      base_temperature <= '0;
      scaling_factor <= CoefW'(65536);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgCount: entry_count <= cfg_data[CntW-1:0];
        CfgBase: base_temperature <= cfg_data[TempW-1:0];
        CfgScale: scaling_factor <= cfg_data[CoefW-1:0];
        default: begin
        end
      endcase
    end
  end

  plct_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .req_type(req_type),
    .entry_index(entry_index), .entry_count(entry_count), .stat(stat),
    .busy(busy), .load_req(load_req), .cmd(cmd), .done(result_valid),
    .st_out(status), .val_sel(val_sel));

  plct_datapath u_dp (
    .clk(clk), .cmd(cmd), .req_temp(temperature), .req_coef(coefficient),
    .base_temperature(base_temperature), .scaling_factor(scaling_factor),
    .load_req(load_req), .load_temp(temperature),
    .stat(stat), .value(value));

  assign coefficient_out = val_sel ? value : '0;
endmodule
`default_nettype wire

// File: rtl/core/plct_ram.sv
// generic single port ram with registered read
`default_nettype none
module plct_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(Depth)-1:0] addr,
  input  wire [Width-1:0]         wdata,
  output logic [Width-1:0]        rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: rtl/core/plct_datapath.sv
// datapath: tables, segment registers, multiplier and serial divider
`default_nettype none
module plct_datapath import plct_pkg::*; (
  input  wire              clk,
  input  cmd_t             cmd,
  input  wire [TempW-1:0]  req_temp,
  input  wire [CoefW-1:0]  req_coef,
  input  wire [TempW-1:0]  base_temperature,
  input  wire [CoefW-1:0]  scaling_factor,
  input  wire              load_req,
  input  wire [TempW-1:0]  load_temp,
  output stat_t            stat,
  output logic [CoefW-1:0] value
);
  logic [TempW-1:0] t_rd, t_key, t0, t_hold;
  logic [CoefW-1:0] c_rd, c0, c1, c_hold, base;
  logic [CoefW-1:0] c_wdata;
  logic [TempW-1:0] t_wdata;
  logic             t_we, c_we;
  logic [ProdW-1:0] prod;
  logic [DivW-1:0]  rem, quo, dvs;
  logic [DivCntW-1:0] dcnt;
  logic             neg;
  logic [TempW-1:0] w;
  logic [DivW:0]    trial;
  logic [CoefW-1:0] nres;

  assign t_we = (cmd.op == OpWrite);
  assign c_we = (cmd.op == OpWrite) || (cmd.op == OpNwrite);
  assign t_wdata = req_temp;
  assign c_wdata = (cmd.op == OpWrite) ? req_coef : nres;
  assign nres = (quo > DivW'(CoefMax)) ? CoefMax : quo[CoefW-1:0];

  plct_ram #(.Width(TempW), .Depth(MaxEntries)) u_tram (
    .clk(clk), .we(t_we), .addr(cmd.addr), .wdata(t_wdata), .rdata(t_rd));
  plct_ram #(.Width(CoefW), .Depth(MaxEntries)) u_cram (
    .clk(clk), .we(c_we), .addr(cmd.addr), .wdata(c_wdata), .rdata(c_rd));

  assign w = t_rd - t_hold;
  assign trial = {rem[DivW-1:0], quo[DivW-1]} - {1'b0, dvs};
  assign stat.bracket = (t_hold <= t_key) && (t_rd >= t_key);
  assign stat.zero_w = (t_rd == t_hold);
  assign stat.div_done = (dcnt == '0);
  assign stat.base_zero = (base == '0);

  always_ff @(posedge clk) begin
    if (load_req) begin
      t_key <= cmd.norm ? base_temperature : load_temp;
    end
    unique case (cmd.op)
      OpScanCmp: begin
        // previous entry held as left end of next segment
        t_hold <= t_rd;
        c_hold <= c_rd;
      end
      OpSegRd: begin
        t0 <= t_hold;
        c0 <= c_hold;
        c1 <= c_rd;
        neg <= c_rd < c_hold;
        dvs <= DivW'(w);
      end
      OpMul: begin
        prod <= (neg ? ProdW'(c0 - c1) : ProdW'(c1 - c0)) * ProdW'(t_key - t0);
      end
      OpDivStart: begin
        rem <= '0;
        quo <= DivW'(prod);
        dcnt <= DivCntW'(DivW);
      end
      OpDivStep: begin
        // the cycle that sees the count at zero only hands over
        if (dcnt != '0) begin
          dcnt <= dcnt - 1'b1;
          if (!trial[DivW]) begin
            rem <= trial[DivW-1:0];
            quo <= {quo[DivW-2:0], 1'b1};
          end else begin
            rem <= {rem[DivW-2:0], quo[DivW-1]};
            quo <= {quo[DivW-2:0], 1'b0};
          end
        end
      end
      OpInterp: begin
        if (cmd.norm) begin
          base <= stat.zero_w ? c_hold : (neg ? c0 - quo[CoefW-1:0] : c0 + quo[CoefW-1:0]);
        end else begin
          value <= stat.zero_w ? c_hold : (neg ? c0 - quo[CoefW-1:0] : c0 + quo[CoefW-1:0]);
        end
      end
      OpNmul: begin
        prod <= ProdW'(c_rd) * ProdW'(scaling_factor);
        dvs <= DivW'(base);
      end
      OpNrdAddr: begin
        // normalize divide reuses divider: numerator with half base added
        quo <= DivW'(prod) + DivW'(base >> 1);
        rem <= '0;
        dcnt <= DivCntW'(DivW);
      end
      OpRdAddr: begin
        value <= '0;
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/core/plct_ctrl.sv
// controller state machine sequencing scan, interpolation and normalize
`default_nettype none
module plct_ctrl import plct_pkg::*; (
  input  wire             clk,
  input  wire             rst,
  input  wire             start,
  input  wire [1:0]       req_type,
  input  wire [IdxW-1:0]  entry_index,
  input  wire [CntW-1:0]  entry_count,
  input  stat_t           stat,
  output logic            busy,
  output logic            load_req,
  output cmd_t            cmd,
  output logic            done,
  output logic [StW-1:0]  st_out,
  output logic            val_sel
);
  `include "piecewise_linear_coeff_table_core_macros.svh"
  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_LD0, S_CMP, S_SEG, S_MUL, S_DIV0, S_DIV, S_INT,
    S_NRD, S_NLD, S_NMUL, S_NDIV0, S_NDIV, S_NWR, S_DONE
  } state_t;
  state_t state;
  logic [CntW-1:0] n, idx;
  logic norm, is_query;
  logic [StW-1:0] st;

  always_comb begin
    cmd.op = OpNone;
    cmd.addr = idx[IdxW-1:0];
    cmd.st = st;
    cmd.norm = norm;
    unique case (state)
      S_RD0: cmd.op = OpRdAddr;
      S_CMP: cmd.op = OpScanCmp;
      S_SEG: cmd.op = OpSegRd;
      S_MUL: cmd.op = OpMul;
      S_DIV0: cmd.op = OpDivStart;
      S_DIV, S_NDIV: cmd.op = OpDivStep;
      S_INT: cmd.op = OpInterp;
      S_NMUL: cmd.op = OpNmul;
      S_NDIV0: cmd.op = OpNrdAddr;
      S_NWR: cmd.op = OpNwrite;
      default: cmd.op = OpNone;
    endcase
    if (state == S_IDLE) begin
      cmd.addr = entry_index;
      cmd.norm = (req_type == ReqNorm);
      if (start && req_type == ReqWrite) begin
        cmd.op = OpWrite;
      end
    end
  end

  assign busy = (state != S_IDLE);
  assign load_req = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      st_out <= StOk;
      val_sel <= 1'b0;
      idx <= '0;
      n <= '0;
      norm <= 1'b0;
      is_query <= 1'b0;
      st <= StOk;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            n <= (entry_count > CntW'(MaxEntries)) ? CntW'(MaxEntries) : entry_count;
            norm <= (req_type == ReqNorm);
            is_query <= (req_type == ReqQuery);
            idx <= '0;
            if (req_type == ReqNorm || req_type == ReqQuery) begin
              state <= S_RD0;
            end else begin
              done <= 1'b1;
              st_out <= StOk;
              val_sel <= 1'b0;
            end
          end
        end
        S_RD0: begin
          if (n < CntW'(2)) begin
            st <= StRange;
            state <= S_DONE;
          end else begin
            state <= S_LD0;
          end
        end
        S_LD0: begin
          // entry 0 stays on the read port so that it can be held
          idx <= CntW'(1);
          state <= S_CMP;
        end
        S_CMP: begin
          // entry idx-1 now held, idx being read
          state <= S_SEG;
        end
        S_SEG: begin
          if (stat.bracket) begin
            state <= S_MUL;
          end else if (idx + 1'b1 >= n) begin
            st <= StRange;
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
            state <= S_CMP;
          end
        end
        S_MUL: state <= S_DIV0;
        S_DIV0: state <= S_DIV;
        S_DIV: if (stat.div_done) state <= S_INT;
        S_INT: begin
          if (norm) begin
            idx <= '0;
            state <= S_NRD;
          end else begin
            st <= StOk;
            state <= S_DONE;
          end
        end
        S_NRD: begin
          if (stat.base_zero) begin
            st <= StZero;
            state <= S_DONE;
          end else begin
            state <= S_NLD;
          end
        end
        S_NLD: state <= S_NMUL;
        S_NMUL: state <= S_NDIV0;
        S_NDIV0: state <= S_NDIV;
        S_NDIV: if (stat.div_done) state <= S_NWR;
        S_NWR: begin
          if (idx + 1'b1 >= n) begin
            st <= StOk;
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
            state <= S_NLD;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          st_out <= st;
          val_sel <= is_query && (st == StOk);
          st <= StOk;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PLC_ASSERT_NEXT(a_done_pulse, done, !done || state == S_IDLE)
  `PLC_ASSERT_IMP(a_busy_no_done, done, state == S_IDLE)
  `PLC_ASSERT_IMP(a_val_query, done && val_sel, st_out == StOk)
endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// testbench for the piecewise linear coefficient table core
`timescale 1ns / 100ps
module tb;
  import plct_pkg::*;

  localparam logic [1:0] ReqNop = 2'd3;

  typedef struct {
    logic [CoefW-1:0] coef;
    logic [StW-1:0]   st;
  } answer_t;

  typedef struct {
    bit               is_cfg;
    logic [1:0]       kind;
    logic [IdxW-1:0]  idx;
    logic [TempW-1:0] temp;
    logic [CoefW-1:0] coef;
    bit               typed;
    logic [CoefW-1:0] exp_coef;
    logic [StW-1:0]   exp_st;
  } row_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [1:0]       req_type;
  logic [IdxW-1:0]  entry_index;
  logic [TempW-1:0] temperature;
  logic [CoefW-1:0] coefficient;
  logic             result_valid;
  logic [CoefW-1:0] coefficient_out;
  logic [StW-1:0]   status;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [CfgW-1:0]  cfg_data;

  piecewise_linear_coeff_table_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .entry_index(entry_index), .temperature(temperature), .coefficient(coefficient),
    .result_valid(result_valid), .coefficient_out(coefficient_out), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow copy of the block state
  logic [6:0]       shadow_count;
  logic [TempW-1:0] shadow_base;
  logic [CoefW-1:0] shadow_scale;
  logic [TempW-1:0] shadow_temp [MaxEntries];
  logic [CoefW-1:0] shadow_coef [MaxEntries];

  answer_t pending_answers[$];
  int      fail_count = 0;
  int      idle_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int live_entries();
    return (shadow_count > MaxEntries) ? MaxEntries : int'(shadow_count);
  endfunction

  function automatic bit lookup_coef(input logic [TempW-1:0] t, output logic [CoefW-1:0] v);
    int n;
    longint unsigned t0, t1, c0, c1, w, d;
    n = live_entries();
    v = '0;
    for (int i = 0; i + 1 < n; i++) begin
      t0 = shadow_temp[i];
      t1 = shadow_temp[i+1];
      if (t0 <= t && t1 >= t) begin
        c0 = shadow_coef[i];
        c1 = shadow_coef[i+1];
        w = t1 - t0;
        d = t - t0;
        if (w == 0) v = CoefW'(c0);
        else if (c1 >= c0) v = CoefW'(c0 + ((c1 - c0) * d) / w);
        else v = CoefW'(c0 - ((c0 - c1) * d) / w);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic answer_t apply_request(input logic [1:0] kind, input logic [IdxW-1:0] ix,
                                            input logic [TempW-1:0] tp,
                                            input logic [CoefW-1:0] cf);
    answer_t a;
    logic [CoefW-1:0] b;
    longint unsigned q;
    a.coef = '0;
    a.st = StOk;
    case (kind)
      ReqWrite: begin
        shadow_temp[ix] = tp;
        shadow_coef[ix] = cf;
      end
      ReqNorm: begin
        if (!lookup_coef(shadow_base, b)) a.st = StRange;
        else if (b == 0) a.st = StZero;
        else begin
          for (int i = 0; i < live_entries(); i++) begin
            q = (longint'(shadow_coef[i]) * longint'(shadow_scale) + (b >> 1)) / b;
            shadow_coef[i] = (q > CoefMax) ? CoefMax : q[CoefW-1:0];
          end
        end
      end
      ReqQuery: begin
        if (!lookup_coef(tp, a.coef)) a.st = StRange;
      end
      default: ;
    endcase
    return a;
  endfunction

  // lowers start and waits until every answer has come back
  task automatic drain();
    start <= 1'b0;
    while (pending_answers.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] ix, input logic [CfgW-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (ix)
      CfgCount: shadow_count = val[6:0];
      CfgBase:  shadow_base = val[TempW-1:0];
      CfgScale: shadow_scale = val[CoefW-1:0];
      default: ;
    endcase
  endtask

  task automatic send_request(input logic [1:0] kind, input logic [IdxW-1:0] ix,
                              input logic [TempW-1:0] tp, input logic [CoefW-1:0] cf,
                              input bit typed, input logic [CoefW-1:0] ec,
                              input logic [StW-1:0] es);
    answer_t a;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= kind;
    entry_index <= ix;
    temperature <= tp;
    coefficient <= cf;
    @(posedge clk);
    while (busy) @(posedge clk);
    a = apply_request(kind, ix, tp, cf);
    if (typed) begin
      a.coef = ec;
      a.st = es;
    end
    pending_answers.push_back(a);
  endtask

  always @(posedge clk) begin
    answer_t a;
    if (!rst && result_valid) begin
      if (pending_answers.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        a = pending_answers.pop_front();
        if (coefficient_out !== a.coef) begin
          $error("coefficient_out expected %0d actual %0d", a.coef, coefficient_out);
          fail_count++;
        end
        if (status !== a.st) begin
          $error("status expected %0d actual %0d", a.st, status);
          fail_count++;
        end
      end
    end
  end

  row_t directed_rows[] = '{
    '{0, ReqQuery, 0, 0, 0, 1, 0, StRange},
    '{0, ReqNorm, 0, 0, 0, 1, 0, StRange},
    '{0, ReqNop, 6'h3f, 16'hffff, CoefMax, 1, 0, StOk},
    '{0, ReqWrite, 0, 100, 0, 1, 0, StOk},
    '{0, ReqWrite, 1, 100, 7, 1, 0, StOk},
    '{0, ReqWrite, 2, 200, CoefMax, 1, 0, StOk},
    '{0, ReqWrite, 3, 16'hffff, 1000, 1, 0, StOk},
    '{0, ReqWrite, 6'h3f, 16'hffff, CoefMax, 1, 0, StOk},
    '{1, CfgCount, 0, 0, 4, 0, 0, 0},
    '{0, ReqQuery, 0, 100, 0, 1, 0, StOk},         // zero-width segment
    '{0, ReqQuery, 0, 99, 0, 1, 0, StRange},
    '{0, ReqQuery, 0, 200, 0, 1, CoefMax, StOk},
    '{0, ReqQuery, 0, 150, 0, 0, 0, 0},
    '{0, ReqQuery, 0, 30000, 0, 0, 0, 0},
    '{0, ReqQuery, 0, 16'hffff, 0, 1, 1000, StOk},
    '{1, CfgBase, 0, 0, 100, 0, 0, 0},
    '{0, ReqNorm, 0, 0, 0, 1, 0, StZero},          // base value zero
    '{1, CfgBase, 0, 0, 150, 0, 0, 0},
    '{1, CfgScale, 0, 0, CoefMax, 0, 0, 0},
    '{0, ReqNorm, 0, 0, 0, 1, 0, StOk},            // saturates
    '{0, ReqQuery, 0, 150, 0, 0, 0, 0},
    '{0, ReqQuery, 0, 16'hffff, 0, 0, 0, 0},
    '{1, CfgCount, 0, 0, 1, 0, 0, 0},
    '{0, ReqQuery, 0, 100, 0, 1, 0, StRange}
  };

  initial begin
    int n_live;
    int n_req;
    int step;
    int pick;
    int t;
    int idle_modes[3] = '{0, 51, 8};
    logic [CoefW-1:0] cf;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    req_type = ReqWrite;
    entry_index = '0;
    temperature = '0;
    coefficient = '0;
    cfg_valid = 1'b0;
    cfg_index = CfgCount;
    cfg_data = '0;
    shadow_count = 0;
    shadow_base = 0;
    shadow_scale = 24'd65536;
    for (int i = 0; i < MaxEntries; i++) begin
      shadow_temp[i] = '0;
      shadow_coef[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].is_cfg) write_reg(directed_rows[k].kind, directed_rows[k].coef);
      else send_request(directed_rows[k].kind, directed_rows[k].idx, directed_rows[k].temp,
                        directed_rows[k].coef, directed_rows[k].typed,
                        directed_rows[k].exp_coef, directed_rows[k].exp_st);
    end

    for (int ph = 0; ph < 9; ph++) begin
      idle_pct = idle_modes[ph % 3];
      case (ph)
        0: write_reg(CfgCount, CfgW'(127));
        1: write_reg(CfgCount, CfgW'(2));
        2: write_reg(CfgCount, CfgW'(64));
        default: write_reg(CfgCount, CfgW'($urandom_range(2, 16)));
      endcase
      n_live = live_entries();
      // ascending table with random content, some zero-width steps
      t = $urandom_range(0, 2000);
      for (int i = 0; i < n_live; i++) begin
        pick = $urandom_range(0, 9);
        cf = (pick == 0) ? '0 : (pick == 1) ? CoefMax : CoefW'($urandom);
        send_request(ReqWrite, IdxW'(i), TempW'(t), cf, 0, 0, 0);
        step = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 65535 / n_live);
        t = (t + step > 65535) ? 65535 : t + step;
      end
      case (ph)
        3: write_reg(CfgBase, CfgW'(0));
        4: write_reg(CfgBase, CfgW'(16'hffff));
        default: write_reg(CfgBase, CfgW'($urandom_range(shadow_temp[0],
                                                         shadow_temp[n_live-1])));
      endcase
      case (ph % 4)
        0: write_reg(CfgScale, CfgW'(0));
        1: write_reg(CfgScale, CfgW'(CoefMax));
        2: write_reg(CfgScale, CfgW'(65536));
        default: write_reg(CfgScale, CfgW'($urandom & CoefMax));
      endcase
      n_req = 24;
      for (int k = 0; k < n_req; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 78)
          send_request(ReqQuery, IdxW'($urandom), TempW'($urandom_range(shadow_temp[0],
                       shadow_temp[n_live-1])), CoefW'($urandom), 0, 0, 0);
        else if (pick < 84)
          send_request(ReqNorm, IdxW'($urandom), TempW'($urandom), CoefW'($urandom),
                       0, 0, 0);
        else if (pick < 92)
          send_request(ReqWrite, IdxW'($urandom_range(0, n_live - 1)), TempW'($urandom),
                       CoefW'($urandom), 0, 0, 0);
        else if (pick < 96)
          send_request(ReqNop, IdxW'($urandom), TempW'($urandom), CoefW'($urandom),
                       0, 0, 0);
        else
          send_request(ReqQuery, IdxW'($urandom), TempW'($urandom), CoefW'($urandom),
                       0, 0, 0);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_answers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/plct_pkg.sv
rtl/core/plct_ram.sv
rtl/core/plct_datapath.sv
rtl/core/plct_ctrl.sv
rtl/core/piecewise_linear_coeff_table_core.sv
tb/sv/tb.sv
